[rtl/tbt_pkg.sv]
// shared types, register indexes, reset values and the interval step function
package tbt_pkg;

  typedef enum logic [2:0] {
    MODE_SET_A  = 3'd0,
    MODE_SET_B  = 3'd1,
    MODE_RUN_A  = 3'd2,
    MODE_RUN_B  = 3'd3,
    MODE_PAUSED = 3'd4
  } mode_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SEC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEC    = 3'd6;

  localparam logic [7:0]  DEBOUNCE_RST   = 8'd40;
  localparam logic [11:0] LONG_PRESS_RST = 12'd800;
  localparam logic [9:0]  LOCKOUT_RST    = 10'd200;
  localparam logic [15:0] TICKS_SEC_RST  = 16'd1000;
  localparam logic [7:0]  STEP_SEC_RST   = 8'd15;
  localparam logic [9:0]  MIN_SEC_RST    = 10'd15;
  localparam logic [9:0]  MAX_SEC_RST    = 10'd240;

  localparam logic [9:0]  INTERVAL_A_RST = 10'd60;
  localparam logic [9:0]  INTERVAL_B_RST = 10'd15;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [11:0] long_press_ticks;
    logic [9:0]  lockout_ms;
    logic [15:0] ticks_per_second;
    logic [7:0]  step_seconds;
    logic [9:0]  min_seconds;
    logic [9:0]  max_seconds;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [9:0]  shown_seconds;
    logic [9:0]  interval_a;
    logic [9:0]  interval_b;
    logic        view_changed;
  } result_t;

  function automatic logic [9:0] next_interval(input logic [9:0] v,
                                               input logic [7:0] step,
                                               input logic [9:0] lo,
                                               input logic [9:0] hi);
    logic [10:0] s;
    logic [9:0]  r;
    s = {1'b0, v} + {3'b000, step};
    if (v >= hi) begin
      r = lo;
    end else if (s < {1'b0, lo}) begin
      r = lo;
    end else if (s > {1'b0, hi}) begin
      r = hi;
    end else begin
      r = s[9:0];
    end
    return r;
  endfunction

endpackage

[rtl/tbt_if.sv]
// tick input and result output channel interfaces
interface tbt_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface tbt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [9:0] shown_seconds;
  logic [9:0] interval_a;
  logic [9:0] interval_b;
  logic       view_changed;

  modport source (output valid, output mode, output shown_seconds, output interval_a,
                  output interval_b, output view_changed, input ready);
  modport sink (input valid, input mode, input shown_seconds, input interval_a,
                input interval_b, input view_changed, output ready);
endinterface

[rtl/tbt_core.sv]
// timer state registers and the per-tick debounce, press and countdown logic
module tbt_core
  import tbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    tick,
  input  logic    button_level,
  output result_t res
);

  mode_t       mode_reg, mode_next;
  logic        paused_from_b, paused_from_b_next;
  logic [9:0]  interval_a_reg, interval_a_next;
  logic [9:0]  interval_b_reg, interval_b_next;
  logic [9:0]  remaining, remaining_next;
  logic        last_raw, last_raw_next;
  logic        stable_level, stable_level_next;
  logic [7:0]  since_raw_change, since_raw_change_next;
  logic        press_active, press_active_next;
  logic        long_done, long_done_next;
  logic [11:0] press_ticks, press_ticks_next;
  logic [9:0]  since_mode_change, since_mode_change_next;
  logic [15:0] second_ticks, second_ticks_next;
  logic        dirty, short_ev, long_ev, locked;
  logic [9:0]  shown;

  always_comb begin
    mode_next              = mode_reg;
    paused_from_b_next     = paused_from_b;
    interval_a_next        = interval_a_reg;
    interval_b_next        = interval_b_reg;
    remaining_next         = remaining;
    last_raw_next          = last_raw;
    stable_level_next      = stable_level;
    press_active_next      = press_active;
    long_done_next         = long_done;
    dirty                  = 1'b0;
    short_ev               = 1'b0;
    since_raw_change_next  = (since_raw_change != 8'hFF) ? since_raw_change + 8'd1
                                                         : since_raw_change;
    press_ticks_next       = (press_ticks != 12'hFFF) ? press_ticks + 12'd1 : press_ticks;
    since_mode_change_next = (since_mode_change != 10'h3FF) ? since_mode_change + 10'd1
                                                            : since_mode_change;
    second_ticks_next      = (second_ticks != 16'hFFFF) ? second_ticks + 16'd1
                                                        : second_ticks;
    locked                 = since_mode_change_next < cfg.lockout_ms;

    // raw edge restarts the debounce window
    if (button_level != last_raw) begin
      since_raw_change_next = 8'd0;
      last_raw_next         = button_level;
    end

    if (since_raw_change_next >= cfg.debounce_ticks && stable_level != button_level) begin
      stable_level_next = button_level;
      if (!button_level) begin
        press_active_next = 1'b1;
        long_done_next    = 1'b0;
        press_ticks_next  = 12'd0;
      end else if (press_active) begin
        short_ev          = !long_done;
        press_active_next = 1'b0;
      end
    end

    long_ev = press_active_next && !long_done_next &&
              press_ticks_next >= cfg.long_press_ticks;
    if (long_ev) begin
      long_done_next = 1'b1;
    end

    if (short_ev && !locked) begin
      case (mode_reg)
        MODE_SET_A: begin
          interval_a_next = next_interval(interval_a_reg, cfg.step_seconds,
                                          cfg.min_seconds, cfg.max_seconds);
          dirty = 1'b1;
        end
        MODE_SET_B: begin
          interval_b_next = next_interval(interval_b_reg, cfg.step_seconds,
                                          cfg.min_seconds, cfg.max_seconds);
          dirty = 1'b1;
        end
        MODE_RUN_A, MODE_RUN_B: begin
          paused_from_b_next     = (mode_reg == MODE_RUN_B);
          mode_next              = MODE_PAUSED;
          since_mode_change_next = 10'd0;
          dirty                  = 1'b1;
        end
        default: begin
          second_ticks_next      = 16'd0;
          mode_next              = paused_from_b ? MODE_RUN_B : MODE_RUN_A;
          since_mode_change_next = 10'd0;
          dirty                  = 1'b1;
        end
      endcase
    end

    if (long_ev && !locked) begin
      case (mode_reg)
        MODE_SET_A: begin
          mode_next = MODE_SET_B;
        end
        MODE_SET_B: begin
          remaining_next    = interval_a_reg;
          second_ticks_next = 16'd0;
          mode_next         = MODE_RUN_A;
        end
        default: begin
          remaining_next = interval_a_reg;
          mode_next      = MODE_SET_A;
        end
      endcase
      since_mode_change_next = 10'd0;
      dirty                  = 1'b1;
    end

    // countdown step
    if ((mode_next == MODE_RUN_A || mode_next == MODE_RUN_B) &&
        second_ticks_next >= cfg.ticks_per_second) begin
      second_ticks_next = second_ticks_next - cfg.ticks_per_second;
      if (remaining_next != 10'd0) begin
        remaining_next = remaining_next - 10'd1;
        dirty          = 1'b1;
      end
      if (remaining_next == 10'd0) begin
        if (mode_next == MODE_RUN_A) begin
          remaining_next = interval_b_next;
          mode_next      = MODE_RUN_B;
        end else begin
          remaining_next = interval_a_next;
          mode_next      = MODE_RUN_A;
        end
        second_ticks_next      = 16'd0;
        since_mode_change_next = 10'd0;
        dirty                  = 1'b1;
      end
    end
  end

  always_comb begin
    case (mode_next)
      MODE_SET_A: shown = interval_a_next;
      MODE_SET_B: shown = interval_b_next;
      default:    shown = remaining_next;
    endcase

    res.mode          = mode_next;
    res.shown_seconds = shown;
    res.interval_a    = interval_a_next;
    res.interval_b    = interval_b_next;
    res.view_changed  = dirty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= MODE_SET_A;
      paused_from_b     <= 1'b0;
      interval_a_reg    <= INTERVAL_A_RST;
      interval_b_reg    <= INTERVAL_B_RST;
      remaining         <= INTERVAL_A_RST;
      last_raw          <= 1'b1;
      stable_level      <= 1'b1;
      since_raw_change  <= 8'hFF;
      press_active      <= 1'b0;
      long_done         <= 1'b0;
      press_ticks       <= 12'd0;
      since_mode_change <= 10'd0;
      second_ticks      <= 16'd0;
    end else if (tick) begin
      mode_reg          <= mode_next;
      paused_from_b     <= paused_from_b_next;
      interval_a_reg    <= interval_a_next;
      interval_b_reg    <= interval_b_next;
      remaining         <= remaining_next;
      last_raw          <= last_raw_next;
      stable_level      <= stable_level_next;
      since_raw_change  <= since_raw_change_next;
      press_active      <= press_active_next;
      long_done         <= long_done_next;
      press_ticks       <= press_ticks_next;
      since_mode_change <= since_mode_change_next;
      second_ticks      <= second_ticks_next;
    end
  end

endmodule

[rtl/tbt_obuf.sv]
// two-entry result buffer: output register plus skid entry
module tbt_obuf
  import tbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/two_interval_button_timer.sv]
// top level: configuration registers, tick processing core and result buffer
// a tick's result is registered in the output buffer before it is offered on out_ch
// throughput: one tick per cycle while out_ch keeps taking results; a stalled
//   output holds one extra result, then in_ch.ready drops until it drains
// reset: config to defaults, mode set A, intervals 60 and 15, buffer empty
module two_interval_button_timer
  import tbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tbt_in_if.sink                in_ch,
  tbt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t step_res, buf_res;
  logic    push_ready, tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
      cfg.lockout_ms       <= LOCKOUT_RST;
      cfg.ticks_per_second <= TICKS_SEC_RST;
      cfg.step_seconds     <= STEP_SEC_RST;
      cfg.min_seconds      <= MIN_SEC_RST;
      cfg.max_seconds      <= MAX_SEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_data[7:0];
        CFG_LONG_PRESS: cfg.long_press_ticks <= cfg_data[11:0];
        CFG_LOCKOUT:    cfg.lockout_ms       <= cfg_data[9:0];
        CFG_TICKS_SEC:  cfg.ticks_per_second <= cfg_data;
        CFG_STEP_SEC:   cfg.step_seconds     <= cfg_data[7:0];
        CFG_MIN_SEC:    cfg.min_seconds      <= cfg_data[9:0];
        CFG_MAX_SEC:    cfg.max_seconds      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = push_ready;
  assign tick        = in_ch.valid && push_ready;

  tbt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick         (tick),
    .button_level (in_ch.button_level),
    .res          (step_res)
  );

  tbt_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (tick),
    .push_data  (step_res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (buf_res)
  );

  assign out_ch.mode          = buf_res.mode;
  assign out_ch.shown_seconds = buf_res.shown_seconds;
  assign out_ch.interval_a    = buf_res.interval_a;
  assign out_ch.interval_b    = buf_res.interval_b;
  assign out_ch.view_changed  = buf_res.view_changed;

endmodule
